[hdl/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg
// Operation and status codes shared by the slot allocator and its checker.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

endpackage

[hdl/sat_ram.sv]
// ----------------------------------------------------------------------------
// sat_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/slot_allocator_with_index_table.sv]
// steps: add ST_ADD_SLOT; remove ST_REM_LAST, ST_REM_MOVE; read ST_RD_SLOT, ST_RD_DATA;
//   each then ST_FINISH; an out-of-range index, an unknown operation or a full add go
//   straight to ST_FINISH, which holds on a stalled output; one item at a time, taken in
//   ST_IDLE; those steps wait on registered reads of order table, free stack, slot store
// reset: synchronous active-low aresetn empties the list and clears the marks;
//   memories are not cleared, since no entry is read before it is written
// ----------------------------------------------------------------------------
// slot_allocator_with_index_table
// Fixed-depth list of data words held in a slot store, with an order table
// mapping logical positions to physical slots and a stack of freed slots.
// ----------------------------------------------------------------------------
module slot_allocator_with_index_table #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int S_W       = sat_pkg::FUNC_W + DATA_WIDTH + IDX_W,
    localparam int S_TDATA_W = ((S_W + 7) / 8) * 8,
    localparam int M_W       = sat_pkg::STATUS_W + DATA_WIDTH + IDX_W + CNT_W,
    localparam int M_TDATA_W = ((M_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // func, item_data, position
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // status, read_data, slot_number, item_count
);

    localparam int FW = sat_pkg::FUNC_W;
    localparam int SW = sat_pkg::STATUS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SLOT,
        ST_REM_LAST,
        ST_REM_MOVE,
        ST_RD_SLOT,
        ST_RD_DATA,
        ST_FINISH
    } state_t;

    // input fields
    logic [FW-1:0]         in_func;
    logic [DATA_WIDTH-1:0] in_data;
    logic [IDX_W-1:0]      in_pos;

    assign in_func = s_axis_tdata[FW-1:0];
    assign in_data = s_axis_tdata[FW +: DATA_WIDTH];
    assign in_pos  = s_axis_tdata[FW + DATA_WIDTH +: IDX_W];

    state_t                state_reg, state_next;
    logic [FW-1:0]         func_reg, func_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [IDX_W-1:0]      last_reg, last_next;
    logic [DATA_WIDTH-1:0] rdata_reg, rdata_next;
    logic [SW-1:0]         status_reg, status_next;
    logic [CNT_W-1:0]      free_depth_reg, free_depth_next;
    logic [CNT_W-1:0]      low_mark_reg, low_mark_next;
    logic [CNT_W-1:0]      high_mark_reg, high_mark_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic                  m_valid_reg, m_valid_next;
    logic [SW-1:0]         m_status_reg, m_status_next;
    logic [DATA_WIDTH-1:0] m_rdata_reg, m_rdata_next;
    logic [IDX_W-1:0]      m_slot_reg, m_slot_next;
    logic [CNT_W-1:0]      m_count_reg, m_count_next;

    // memory ports
    logic                  order_we;
    logic [IDX_W-1:0]      order_wa, order_wd, order_ra, order_rd;
    logic                  stack_we;
    logic [IDX_W-1:0]      stack_wa, stack_ra, stack_rd;
    logic                  store_we;
    logic [DATA_WIDTH-1:0] store_rd;

    logic out_free;

    sat_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_order_table (
        .aclk    (aclk),
        .wr_en   (order_we),
        .wr_addr (order_wa),
        .wr_data (order_wd),
        .rd_addr (order_ra),
        .rd_data (order_rd)
    );

    sat_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_free_stack (
        .aclk    (aclk),
        .wr_en   (stack_we),
        .wr_addr (stack_wa),
        .wr_data (slot_reg),
        .rd_addr (stack_ra),
        .rd_data (stack_rd)
    );

    sat_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_slot_store (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (slot_reg),
        .wr_data (data_reg),
        .rd_addr (order_rd),
        .rd_data (store_rd)
    );

    // reads: order table at the requested position on accept, at the last
    // entry while a remove runs; the top of the free stack is always fetched
    assign order_ra = (state_reg == ST_IDLE) ? in_pos : IDX_W'(total_reg - CNT_W'(1));
    assign stack_ra = IDX_W'(free_depth_reg - CNT_W'(1));
    assign stack_wa = IDX_W'(free_depth_reg);

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        data_next       = data_reg;
        pos_next        = pos_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;
        rdata_next      = rdata_reg;
        status_next     = status_reg;
        free_depth_next = free_depth_reg;
        low_mark_next   = low_mark_reg;
        high_mark_next  = high_mark_reg;
        total_next      = total_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_status_next   = m_status_reg;
        m_rdata_next    = m_rdata_reg;
        m_slot_next     = m_slot_reg;
        m_count_next    = m_count_reg;
        order_we        = 1'b0;
        order_wa        = pos_reg;
        order_wd        = last_reg;
        stack_we        = 1'b0;
        store_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    func_next   = in_func;
                    data_next   = in_data;
                    pos_next    = in_pos;
                    status_next = sat_pkg::STATUS_OK;
                    slot_next   = '0;
                    rdata_next  = '0;
                    if (in_func == sat_pkg::FUNC_ADD) begin
                        if (total_reg == CNT_W'(DEPTH)) begin
                            status_next = sat_pkg::STATUS_FULL;
                            state_next  = ST_FINISH;
                        end else begin
                            state_next  = ST_ADD_SLOT;
                        end
                    end else if (in_func == sat_pkg::FUNC_REMOVE ||
                                 in_func == sat_pkg::FUNC_READ) begin
                        if (CNT_W'(in_pos) >= total_reg) begin
                            status_next = sat_pkg::STATUS_RANGE;
                            state_next  = ST_FINISH;
                        end else if (in_func == sat_pkg::FUNC_REMOVE) begin
                            state_next  = ST_REM_LAST;
                        end else begin
                            state_next  = ST_RD_SLOT;
                        end
                    end else begin
                        status_next = sat_pkg::STATUS_RANGE;
                        state_next  = ST_FINISH;
                    end
                end
            end
            ST_ADD_SLOT: begin
                // freed stack first, then below the low mark, then the high mark
                priority if (free_depth_reg != '0) begin
                    slot_next = stack_rd;
                end else if (low_mark_reg != '0) begin
                    slot_next = IDX_W'(low_mark_reg - CNT_W'(1));
                end else begin
                    slot_next = IDX_W'(high_mark_reg);
                end
                state_next = ST_FINISH;
            end
            ST_REM_LAST: begin
                slot_next  = order_rd;
                state_next = ST_REM_MOVE;
            end
            ST_REM_MOVE: begin
                last_next  = order_rd;
                state_next = ST_FINISH;
            end
            ST_RD_SLOT: begin
                slot_next  = order_rd;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                rdata_next = store_rd;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    if (status_reg == sat_pkg::STATUS_OK) begin
                        case (func_reg)
                            sat_pkg::FUNC_ADD: begin
                                order_we = 1'b1;
                                order_wa = IDX_W'(total_reg);
                                order_wd = slot_reg;
                                store_we = 1'b1;
                                priority if (free_depth_reg != '0) begin
                                    free_depth_next = free_depth_reg - CNT_W'(1);
                                end else if (low_mark_reg != '0) begin
                                    low_mark_next = low_mark_reg - CNT_W'(1);
                                end else begin
                                    high_mark_next = high_mark_reg + CNT_W'(1);
                                end
                                total_next = total_reg + CNT_W'(1);
                            end
                            sat_pkg::FUNC_REMOVE: begin
                                // last entry fills the hole
                                order_we = 1'b1;
                                priority if (high_mark_reg != '0 &&
                                             CNT_W'(slot_reg) == high_mark_reg - CNT_W'(1)) begin
                                    high_mark_next = high_mark_reg - CNT_W'(1);
                                end else if (CNT_W'(slot_reg) == low_mark_reg) begin
                                    low_mark_next = low_mark_reg + CNT_W'(1);
                                end else begin
                                    stack_we        = 1'b1;
                                    free_depth_next = free_depth_reg + CNT_W'(1);
                                end
                                total_next = total_reg - CNT_W'(1);
                            end
                            default: begin
                            end
                        endcase
                    end
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_rdata_next  = rdata_reg;
                    m_slot_next   = slot_reg;
                    m_count_next  = total_next;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            free_depth_reg <= '0;
            low_mark_reg   <= '0;
            high_mark_reg  <= '0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_depth_reg <= free_depth_next;
            low_mark_reg   <= low_mark_next;
            high_mark_reg  <= high_mark_next;
            total_reg      <= total_next;
            m_valid_reg    <= m_valid_next;
            func_reg       <= func_next;
            data_reg       <= data_next;
            pos_reg        <= pos_next;
            slot_reg       <= slot_next;
            last_reg       <= last_next;
            rdata_reg      <= rdata_next;
            status_reg     <= status_next;
            m_status_reg   <= m_status_next;
            m_rdata_reg    <= m_rdata_next;
            m_slot_reg     <= m_slot_next;
            m_count_reg    <= m_count_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({m_count_reg, m_slot_reg, m_rdata_reg, m_status_reg});

endmodule

[hdl/sat_checker.sv]
// ----------------------------------------------------------------------------
// sat_checker
// Port-level checks on the slot allocator, attached by bind.
// ----------------------------------------------------------------------------
module sat_checker #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int M_W       = sat_pkg::STATUS_W + DATA_WIDTH + IDX_W + CNT_W,
    localparam int M_TDATA_W = ((M_W + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int SW = sat_pkg::STATUS_W;

    logic [SW-1:0]    m_status;
    logic [CNT_W-1:0] m_count;

    assign m_status = m_axis_tdata[SW-1:0];
    assign m_count  = m_axis_tdata[SW + DATA_WIDTH + IDX_W +: CNT_W];

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in flight: input closes right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_count <= CNT_W'(DEPTH))
        else $error("item count beyond depth");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_status == sat_pkg::STATUS_FULL |-> m_count == CNT_W'(DEPTH))
        else $error("full status with list not full");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_status == sat_pkg::STATUS_OK || m_status == sat_pkg::STATUS_FULL
                          || m_status == sat_pkg::STATUS_RANGE)
        else $error("undefined status code");

endmodule

bind slot_allocator_with_index_table sat_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_sat_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
